// ----- hw/rtl/afpr_pkg.sv -----
// Shared types, codes and constants of the ASCII framed packet receiver.
package afpr_pkg;

  localparam int ADDRESS_CHARS_DEF    = 8;
  localparam int COMMAND_CHARS_DEF    = 8;
  localparam int DATA_CHARS_DEF       = 32;
  localparam int MAX_FRAME_LENGTH_DEF = 54;

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_SEP   = 8'h3B;
  localparam logic [7:0] CH_END   = 8'h0A;
  localparam logic [7:0] CH_SUBST = 8'h1A;
  localparam logic [8:0] SUM_MOD  = 9'd255;

  localparam logic [2:0] STAT_TAKEN    = 3'd0;
  localparam logic [2:0] STAT_ACCEPTED = 3'd1;
  localparam logic [2:0] STAT_CHECK    = 3'd2;
  localparam logic [2:0] STAT_ADDRESS  = 3'd3;
  localparam logic [2:0] STAT_OVERFLOW = 3'd4;
  localparam logic [2:0] STAT_BUSY     = 3'd5;
  localparam logic [2:0] STAT_RELEASED = 3'd6;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_COMMAND = 2'd1;
  localparam logic [1:0] KIND_DATA    = 2'd2;

  localparam logic MODE_BYTE    = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  localparam logic CFG_OWN_ADDRESS     = 1'b0;
  localparam logic CFG_OWN_ADDRESS_LEN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ADDR_RD,
    ST_ADDR_CMP,
    ST_HEAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [2:0] status;
    logic [1:0] kind;
    logic [7:0] char_value;
    logic [3:0] command_length;
    logic [5:0] data_length;
    logic       last;
  } result_t;

endpackage

// ----- hw/rtl/afpr_out_queue.sv -----
// Two-entry result queue between the frame sequencer and the output channel.
module afpr_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  afpr_pkg::result_t push_item,
  input  logic              pop,
  output afpr_pkg::result_t head,
  output logic              head_valid,
  output logic [1:0]        count
);

  afpr_pkg::result_t q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_pop;

  assign head       = q_r[rp_r];
  assign head_valid = (count_r != 2'd0);
  assign count      = count_r;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wp_nxt    = push ? ~wp_r : wp_r;
    rp_nxt    = do_pop ? ~rp_r : rp_r;
    count_nxt = count_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_item;
    end
  end

endmodule

// ----- hw/rtl/ascii_framed_packet_receiver_top.sv -----
// Top level of the ASCII framed packet receiver: field splitting, check and address test.
//
//  channel  dir  handshake               payload
//  in_      in   in_tvalid / in_tready   tdata rx_byte, tuser mode
//  out_     out  out_tvalid / out_tready tdata status..data_length, tuser item_kind, tlast
//  cfg_     in   cfg_wr_en               cfg_index, cfg_data
//
// A byte is taken whenever the sequencer is idle and the two-entry result queue has room.
// A newline runs the sequencer: the check, then for each address character a read and
// a compare on the character memory's single read port, then the header, then the
// command and data characters, a read being issued only when the two-entry queue is
// sure to have room for its beat.
// Reset is synchronous and needs no clearing pass; no character memory data past the fill
// counts is ever used. A stalled output only holds the sequencer and the input side.
module ascii_framed_packet_receiver_top #(
  parameter int ADDRESS_CHARS    = afpr_pkg::ADDRESS_CHARS_DEF,
  parameter int COMMAND_CHARS    = afpr_pkg::COMMAND_CHARS_DEF,
  parameter int DATA_CHARS       = afpr_pkg::DATA_CHARS_DEF,
  parameter int MAX_FRAME_LENGTH = afpr_pkg::MAX_FRAME_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [2:0] status, [10:3] char_value, [14:11] command_length,
                                  // [20:15] data_length, [23:21] zero
  output logic [1:0]  out_tuser,  // [1:0] item_kind
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int MEM_DEPTH = ADDRESS_CHARS + COMMAND_CHARS + DATA_CHARS;
  localparam int MAW       = $clog2(MEM_DEPTH);
  localparam int CMD_BASE  = ADDRESS_CHARS;
  localparam int DATA_BASE = ADDRESS_CHARS + COMMAND_CHARS;
  localparam int ACW       = $clog2(ADDRESS_CHARS + 1);
  localparam int CCW       = $clog2(COMMAND_CHARS + 1);
  localparam int DCW       = $clog2(DATA_CHARS + 1);
  localparam int FLW       = $clog2(MAX_FRAME_LENGTH + 1);
  localparam int TW        = $clog2(COMMAND_CHARS + DATA_CHARS + 1);

  // Configuration.
  logic [63:0] own_address_r;
  logic [3:0]  own_address_len_r;

  // Frame state.
  afpr_pkg::state_t state_r, state_nxt;
  logic           in_frame_r, in_frame_nxt;
  logic           frame_held_r, frame_held_nxt;
  logic [FLW-1:0] frame_length_r, frame_length_nxt;
  logic [2:0]     field_number_r, field_number_nxt;
  logic [FLW-1:0] field_position_r, field_position_nxt;
  logic [7:0]     running_sum_r, running_sum_nxt;
  logic [7:0]     sum_before_last_r, sum_before_last_nxt;
  logic [ACW-1:0] address_count_r, address_count_nxt;
  logic [CCW-1:0] command_count_r, command_count_nxt;
  logic [DCW-1:0] data_count_r, data_count_nxt;
  logic [7:0]     check_char_r, check_char_nxt;
  logic           check_present_r, check_present_nxt;

  // Sequencer state.
  logic           got_from_mem_r, got_from_mem_nxt;
  logic [7:0]     got_value_r, got_value_nxt;
  logic [ACW-1:0] addr_idx_r, addr_idx_nxt;
  logic [TW-1:0]  issue_idx_r, issue_idx_nxt;
  logic           pend_r, pend_nxt;
  logic [1:0]     pend_kind_r, pend_kind_nxt;
  logic           pend_last_r, pend_last_nxt;

  // Character memory: address, command and data regions.
  logic [7:0]     mem_r [MEM_DEPTH];
  logic [7:0]     rd_data_r;
  logic           mem_we;
  logic [MAW-1:0] mem_wa;
  logic [7:0]     mem_wd;
  logic           rd_en;
  logic [MAW-1:0] rd_addr;

  // Result queue.
  logic              q_push;
  afpr_pkg::result_t q_item;
  afpr_pkg::result_t q_head;
  logic              q_head_valid;
  logic [1:0]        q_count;

  logic           in_fire;
  logic           q_room;
  logic [7:0]     rx_byte;
  logic [FLW-1:0] frame_length_inc;
  logic [8:0]     sum_wide;
  logic [7:0]     check_sum;
  logic [7:0]     got_char;
  logic [7:0]     own_byte;
  logic [TW-1:0]  total_chars;
  logic           issue_ok;
  logic           clear_fields;

  assign q_room           = (q_count != 2'd2);
  assign in_tready        = (state_r == afpr_pkg::ST_IDLE) && q_room;
  assign in_fire          = in_tvalid && in_tready;
  assign rx_byte          = in_tdata;
  assign frame_length_inc = frame_length_r + 1'b1;
  assign sum_wide         = {1'b0, running_sum_r} + {1'b0, rx_byte};
  assign check_sum        = (sum_before_last_r == afpr_pkg::CH_START ||
                             sum_before_last_r == afpr_pkg::CH_SEP) ?
                            afpr_pkg::CH_SUBST : sum_before_last_r;
  assign got_char         = got_from_mem_r ? rd_data_r : got_value_r;
  assign own_byte         = own_address_r[8*addr_idx_r +: 8];
  assign total_chars      = TW'(command_count_r) + TW'(data_count_r);
  assign issue_ok         = (issue_idx_r < total_chars) &&
                            (q_count == 2'd0 || (q_count == 2'd1 && !pend_r));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      afpr_pkg::ST_IDLE: begin
        if (in_fire && in_tuser == afpr_pkg::MODE_BYTE && !frame_held_r && in_frame_r &&
            rx_byte == afpr_pkg::CH_END && int'(frame_length_inc) < MAX_FRAME_LENGTH) begin
          state_nxt = afpr_pkg::ST_CHECK;
        end
      end
      afpr_pkg::ST_CHECK: begin
        if (q_room) begin
          if (got_char != check_sum || own_address_len_r != 4'(address_count_r)) begin
            state_nxt = afpr_pkg::ST_IDLE;
          end else if (address_count_r == '0) begin
            state_nxt = afpr_pkg::ST_HEAD;
          end else begin
            state_nxt = afpr_pkg::ST_ADDR_RD;
          end
        end
      end
      afpr_pkg::ST_ADDR_RD: begin
        state_nxt = afpr_pkg::ST_ADDR_CMP;
      end
      afpr_pkg::ST_ADDR_CMP: begin
        if (rd_data_r != own_byte) begin
          if (q_room) begin
            state_nxt = afpr_pkg::ST_IDLE;
          end
        end else if (addr_idx_r + 1'b1 == address_count_r) begin
          state_nxt = afpr_pkg::ST_HEAD;
        end else begin
          state_nxt = afpr_pkg::ST_ADDR_RD;
        end
      end
      afpr_pkg::ST_HEAD: begin
        if (q_room) begin
          state_nxt = (total_chars == '0) ? afpr_pkg::ST_IDLE : afpr_pkg::ST_EMIT;
        end
      end
      afpr_pkg::ST_EMIT: begin
        if (issue_idx_r == total_chars && !pend_r) begin
          state_nxt = afpr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = afpr_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    in_frame_nxt        = in_frame_r;
    frame_held_nxt      = frame_held_r;
    frame_length_nxt    = frame_length_r;
    field_number_nxt    = field_number_r;
    field_position_nxt  = field_position_r;
    running_sum_nxt     = running_sum_r;
    sum_before_last_nxt = sum_before_last_r;
    address_count_nxt   = address_count_r;
    command_count_nxt   = command_count_r;
    data_count_nxt      = data_count_r;
    check_char_nxt      = check_char_r;
    check_present_nxt   = check_present_r;
    got_from_mem_nxt    = got_from_mem_r;
    got_value_nxt       = got_value_r;
    addr_idx_nxt        = addr_idx_r;
    issue_idx_nxt       = issue_idx_r;
    pend_nxt            = pend_r;
    pend_kind_nxt       = pend_kind_r;
    pend_last_nxt       = pend_last_r;
    clear_fields        = 1'b0;
    mem_we              = 1'b0;
    mem_wa              = '0;
    mem_wd              = rx_byte;
    rd_en               = 1'b0;
    rd_addr             = '0;
    q_push              = 1'b0;
    q_item              = '0;
    q_item.last         = 1'b1;

    case (state_r)
      afpr_pkg::ST_IDLE: begin
        if (in_fire) begin
          q_push        = 1'b1;
          q_item.status = afpr_pkg::STAT_TAKEN;
          if (in_tuser == afpr_pkg::MODE_RELEASE) begin
            q_item.status = afpr_pkg::STAT_RELEASED;
            if (frame_held_r) begin
              frame_held_nxt = 1'b0;
              clear_fields   = 1'b1;
            end
          end else if (frame_held_r) begin
            q_item.status = afpr_pkg::STAT_BUSY;
          end else if (rx_byte == afpr_pkg::CH_START) begin
            // A start character opens a frame, or restarts one in progress.
            clear_fields        = 1'b1;
            in_frame_nxt        = 1'b1;
            frame_length_nxt    = FLW'(1);
            sum_before_last_nxt = 8'd0;
            running_sum_nxt     = afpr_pkg::CH_START;
          end else if (in_frame_r) begin
            frame_length_nxt = frame_length_inc;
            if (int'(frame_length_inc) >= MAX_FRAME_LENGTH) begin
              in_frame_nxt  = 1'b0;
              clear_fields  = 1'b1;
              q_item.status = afpr_pkg::STAT_OVERFLOW;
            end else if (rx_byte != afpr_pkg::CH_END) begin
              sum_before_last_nxt = running_sum_r;
              running_sum_nxt     = (sum_wide >= afpr_pkg::SUM_MOD) ?
                                    8'(sum_wide - afpr_pkg::SUM_MOD) : sum_wide[7:0];
              if (rx_byte == afpr_pkg::CH_SEP) begin
                if (field_number_r < 3'd4) begin
                  field_number_nxt = field_number_r + 3'd1;
                end
                field_position_nxt = '0;
              end else begin
                field_position_nxt = field_position_r + 1'b1;
                if (field_number_r == 3'd0 && int'(field_position_r) < ADDRESS_CHARS) begin
                  mem_we            = 1'b1;
                  mem_wa            = MAW'(address_count_r);
                  address_count_nxt = address_count_r + 1'b1;
                end else if (field_number_r == 3'd1 &&
                             int'(field_position_r) < COMMAND_CHARS) begin
                  mem_we            = 1'b1;
                  mem_wa            = MAW'(CMD_BASE) + MAW'(command_count_r);
                  command_count_nxt = command_count_r + 1'b1;
                end else if (field_number_r == 3'd2 &&
                             int'(field_position_r) < DATA_CHARS) begin
                  mem_we         = 1'b1;
                  mem_wa         = MAW'(DATA_BASE) + MAW'(data_count_r);
                  data_count_nxt = data_count_r + 1'b1;
                end else if (field_number_r == 3'd3 && field_position_r == '0) begin
                  check_char_nxt    = rx_byte;
                  check_present_nxt = 1'b1;
                end
              end
            end else begin
              // Newline: pick the check character, then the sequencer takes over.
              q_push           = 1'b0;
              in_frame_nxt     = 1'b0;
              rd_en            = 1'b1;
              rd_addr          = MAW'(DATA_BASE);
              got_from_mem_nxt = (field_number_r == 3'd2) && (data_count_r != '0);
              got_value_nxt    = (field_number_r >= 3'd3 && check_present_r) ?
                                 check_char_r : 8'd0;
              if (field_number_r == 3'd2) begin
                data_count_nxt = '0;
              end
            end
          end
        end
      end
      afpr_pkg::ST_CHECK: begin
        addr_idx_nxt = '0;
        if (q_room) begin
          if (got_char != check_sum) begin
            q_push        = 1'b1;
            q_item.status = afpr_pkg::STAT_CHECK;
            clear_fields  = 1'b1;
          end else if (own_address_len_r != 4'(address_count_r)) begin
            q_push        = 1'b1;
            q_item.status = afpr_pkg::STAT_ADDRESS;
            clear_fields  = 1'b1;
          end
        end
      end
      afpr_pkg::ST_ADDR_RD: begin
        rd_en   = 1'b1;
        rd_addr = MAW'(addr_idx_r);
      end
      afpr_pkg::ST_ADDR_CMP: begin
        if (rd_data_r != own_byte) begin
          if (q_room) begin
            q_push        = 1'b1;
            q_item.status = afpr_pkg::STAT_ADDRESS;
            clear_fields  = 1'b1;
          end
        end else begin
          addr_idx_nxt = addr_idx_r + 1'b1;
        end
      end
      afpr_pkg::ST_HEAD: begin
        issue_idx_nxt = '0;
        pend_nxt      = 1'b0;
        if (q_room) begin
          q_push                = 1'b1;
          q_item.status         = afpr_pkg::STAT_ACCEPTED;
          q_item.kind           = afpr_pkg::KIND_HEADER;
          q_item.command_length = 4'(command_count_r);
          q_item.data_length    = 6'(data_count_r);
          q_item.last           = (total_chars == '0);
          frame_held_nxt        = 1'b1;
        end
      end
      afpr_pkg::ST_EMIT: begin
        // A read issued now returns next cycle; issue only when the queue will have room.
        if (pend_r) begin
          q_push            = 1'b1;
          q_item.status     = afpr_pkg::STAT_ACCEPTED;
          q_item.kind       = pend_kind_r;
          q_item.char_value = rd_data_r;
          q_item.last       = pend_last_r;
        end
        pend_nxt = issue_ok;
        if (issue_ok) begin
          rd_en         = 1'b1;
          issue_idx_nxt = issue_idx_r + 1'b1;
          pend_last_nxt = (issue_idx_r + 1'b1 == total_chars);
          if (issue_idx_r < TW'(command_count_r)) begin
            rd_addr       = MAW'(CMD_BASE) + MAW'(issue_idx_r);
            pend_kind_nxt = afpr_pkg::KIND_COMMAND;
          end else begin
            rd_addr       = MAW'(DATA_BASE) + MAW'(issue_idx_r - TW'(command_count_r));
            pend_kind_nxt = afpr_pkg::KIND_DATA;
          end
        end
      end
      default: ;
    endcase

    if (clear_fields) begin
      address_count_nxt  = '0;
      command_count_nxt  = '0;
      data_count_nxt     = '0;
      check_char_nxt     = 8'd0;
      check_present_nxt  = 1'b0;
      field_number_nxt   = 3'd0;
      field_position_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r     <= 64'd0;
      own_address_len_r <= 4'd0;
    end else if (cfg_wr_en) begin
      if (cfg_index == afpr_pkg::CFG_OWN_ADDRESS) begin
        own_address_r <= cfg_data;
      end else if (cfg_index == afpr_pkg::CFG_OWN_ADDRESS_LEN) begin
        own_address_len_r <= cfg_data[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= afpr_pkg::ST_IDLE;
      in_frame_r        <= 1'b0;
      frame_held_r      <= 1'b0;
      frame_length_r    <= '0;
      field_number_r    <= 3'd0;
      field_position_r  <= '0;
      running_sum_r     <= 8'd0;
      sum_before_last_r <= 8'd0;
      address_count_r   <= '0;
      command_count_r   <= '0;
      data_count_r      <= '0;
      check_char_r      <= 8'd0;
      check_present_r   <= 1'b0;
      pend_r            <= 1'b0;
    end else begin
      state_r           <= state_nxt;
      in_frame_r        <= in_frame_nxt;
      frame_held_r      <= frame_held_nxt;
      frame_length_r    <= frame_length_nxt;
      field_number_r    <= field_number_nxt;
      field_position_r  <= field_position_nxt;
      running_sum_r     <= running_sum_nxt;
      sum_before_last_r <= sum_before_last_nxt;
      address_count_r   <= address_count_nxt;
      command_count_r   <= command_count_nxt;
      data_count_r      <= data_count_nxt;
      check_char_r      <= check_char_nxt;
      check_present_r   <= check_present_nxt;
      pend_r            <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    got_from_mem_r <= got_from_mem_nxt;
    got_value_r    <= got_value_nxt;
    addr_idx_r     <= addr_idx_nxt;
    issue_idx_r    <= issue_idx_nxt;
    pend_kind_r    <= pend_kind_nxt;
    pend_last_r    <= pend_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  afpr_out_queue u_out_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .pop        (out_tready),
    .head       (q_head),
    .head_valid (q_head_valid),
    .count      (q_count)
  );

  assign out_tvalid = q_head_valid;
  assign out_tdata  = {3'b000, q_head.data_length, q_head.command_length,
                       q_head.char_value, q_head.status};
  assign out_tuser  = q_head.kind;
  assign out_tlast  = q_head.last;

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_count != 2'd2 || (out_tready && q_head_valid)))
    else $error("result queue overflow");

  a_held_not_receiving: assert property (@(posedge clk) disable iff (!rst_n)
    frame_held_r |-> !in_frame_r)
    else $error("frame held while another frame is being received");

  a_hold_after_header: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(frame_held_r) |-> ($past(q_push) &&
                             $past(q_item.status) == afpr_pkg::STAT_ACCEPTED &&
                             $past(q_item.kind) == afpr_pkg::KIND_HEADER))
    else $error("frame held without an accepted header");

  a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == afpr_pkg::ST_IDLE && !rd_en))
    else $error("character memory written outside byte intake");

endmodule

// ----- bench/frame_scoreboard_pkg.sv -----
// Scoreboard that predicts the replies of the ASCII frame receiver and checks them.
`timescale 1ns / 1ps

package frame_scoreboard_pkg;
  import afpr_pkg::*;

  class frame_scoreboard;
    bit [63:0] own_addr;
    bit [3:0]  own_len;

    bit        in_frame;
    bit        held;
    bit [5:0]  flen;
    bit [2:0]  fnum;
    bit [5:0]  fpos;
    bit [7:0]  rsum;
    bit [7:0]  prev_sum;
    bit [7:0]  addr_chars [ADDRESS_CHARS_DEF];
    bit [3:0]  addr_cnt;
    bit [7:0]  cmd_chars [COMMAND_CHARS_DEF];
    bit [3:0]  cmd_cnt;
    bit [7:0]  data_chars [DATA_CHARS_DEF];
    bit [5:0]  data_cnt;
    bit [7:0]  chk;
    bit        chk_seen;

    result_t   expected_replies[$];
    int        errors;

    function int pending();
      return expected_replies.size();
    endfunction

    function void set_register(bit idx, bit [63:0] value);
      if (idx == CFG_OWN_ADDRESS) begin
        own_addr = value;
      end else begin
        own_len = value[3:0];
      end
    endfunction

    function void add_reply(bit [2:0] st, bit [1:0] kind, bit [7:0] ch, bit [3:0] cl,
                            bit [5:0] dl, bit last);
      result_t r;
      r.status = st;
      r.kind = kind;
      r.char_value = ch;
      r.command_length = cl;
      r.data_length = dl;
      r.last = last;
      expected_replies.push_back(r);
    endfunction

    function void clear_fields();
      addr_cnt = 0;
      cmd_cnt = 0;
      data_cnt = 0;
      chk = 0;
      chk_seen = 0;
      fnum = 0;
      fpos = 0;
    endfunction

    function void open_frame();
      clear_fields();
      in_frame = 1;
      flen = 1;
      prev_sum = 0;
      rsum = CH_START;
    endfunction

    function void take_char(bit [7:0] b);
      if (b == CH_SEP) begin
        if (fnum < 4) fnum++;
        fpos = 0;
        return;
      end
      if (fnum == 0 && fpos < ADDRESS_CHARS_DEF) begin
        addr_chars[addr_cnt] = b;
        addr_cnt++;
      end else if (fnum == 1 && fpos < COMMAND_CHARS_DEF) begin
        cmd_chars[cmd_cnt] = b;
        cmd_cnt++;
      end else if (fnum == 2 && fpos < DATA_CHARS_DEF) begin
        data_chars[data_cnt] = b;
        data_cnt++;
      end else if (fnum == 3 && fpos == 0) begin
        chk = b;
        chk_seen = 1;
      end
      if (fpos != 6'h3F) fpos++;
    endfunction

    // Works out every reply that one accepted beat causes.
    function void absorb_item(bit mode, bit [7:0] b);
      bit [7:0] want_sum;
      bit [7:0] got_sum;
      bit       addr_ok;
      if (mode == MODE_RELEASE) begin
        if (held) begin
          held = 0;
          clear_fields();
        end
        add_reply(STAT_RELEASED, KIND_HEADER, 0, 0, 0, 1);
        return;
      end
      if (held) begin
        add_reply(STAT_BUSY, KIND_HEADER, 0, 0, 0, 1);
        return;
      end
      if (!in_frame || b == CH_START) begin
        if (b == CH_START) open_frame();
        add_reply(STAT_TAKEN, KIND_HEADER, 0, 0, 0, 1);
        return;
      end
      flen++;
      if (flen >= MAX_FRAME_LENGTH_DEF) begin
        in_frame = 0;
        clear_fields();
        add_reply(STAT_OVERFLOW, KIND_HEADER, 0, 0, 0, 1);
        return;
      end
      if (b != CH_END) begin
        take_char(b);
        prev_sum = rsum;
        rsum = 8'((int'(rsum) + int'(b)) % 255);
        add_reply(STAT_TAKEN, KIND_HEADER, 0, 0, 0, 1);
        return;
      end

      in_frame = 0;
      want_sum = prev_sum;
      if (want_sum == CH_START || want_sum == CH_SEP) want_sum = CH_SUBST;
      // With only two separators the check character sits in the data field.
      if (fnum == 2) begin
        got_sum = (data_cnt != 0) ? data_chars[0] : 8'h00;
        data_cnt = 0;
      end else if (fnum >= 3) begin
        got_sum = chk_seen ? chk : 8'h00;
      end else begin
        got_sum = 8'h00;
      end
      if (got_sum != want_sum) begin
        clear_fields();
        add_reply(STAT_CHECK, KIND_HEADER, 0, 0, 0, 1);
        return;
      end
      addr_ok = (own_len == addr_cnt);
      for (int k = 0; k < addr_cnt; k++) begin
        if (own_addr[8*k +: 8] != addr_chars[k]) addr_ok = 0;
      end
      if (!addr_ok) begin
        clear_fields();
        add_reply(STAT_ADDRESS, KIND_HEADER, 0, 0, 0, 1);
        return;
      end
      held = 1;
      add_reply(STAT_ACCEPTED, KIND_HEADER, 0, cmd_cnt, data_cnt,
                (cmd_cnt == 0 && data_cnt == 0));
      for (int k = 0; k < cmd_cnt; k++) begin
        add_reply(STAT_ACCEPTED, KIND_COMMAND, cmd_chars[k], 0, 0,
                  (k + 1 == cmd_cnt && data_cnt == 0));
      end
      for (int k = 0; k < data_cnt; k++) begin
        add_reply(STAT_ACCEPTED, KIND_DATA, data_chars[k], 0, 0, (k + 1 == data_cnt));
      end
    endfunction

    function void match_reply(result_t got);
      result_t want;
      if (expected_replies.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected reply: status=%0d kind=%0d char=%02h cl=%0d dl=%0d last=%0d",
                   got.status, got.kind, got.char_value, got.command_length,
                   got.data_length, got.last);
        end
        return;
      end
      want = expected_replies.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("reply mismatch: expected status=%0d kind=%0d char=%02h cl=%0d dl=%0d last=%0d",
                   want.status, want.kind, want.char_value, want.command_length,
                   want.data_length, want.last);
          $display("                got      status=%0d kind=%0d char=%02h cl=%0d dl=%0d last=%0d",
                   got.status, got.kind, got.char_value, got.command_length,
                   got.data_length, got.last);
        end
      end
    endfunction
  endclass

endpackage

// ----- bench/tb_top.sv -----
// Testbench top: drives frames, noise and releases into the receiver and checks every reply.
`timescale 1ns / 1ps

module tb_top;
  import afpr_pkg::*;
  import frame_scoreboard_pkg::*;

  typedef struct packed {
    bit       mode;
    bit [7:0] value;
  } rx_item_t;

  logic        clk = 0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [63:0] cfg_data;

  frame_scoreboard sb = new();

  rx_item_t  tx_items[$];
  bit        quiet;
  bit        long_hold_req;
  int        gap_pct = 15;
  int        stall_pct = 15;
  bit [63:0] addr_now;
  bit [3:0]  len_now;
  int        phase_items;

  ascii_framed_packet_receiver_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int pick_rate();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 15;
      default: return 45;
    endcase
  endfunction

  // A random character that cannot be taken for a frame delimiter.
  function automatic bit [7:0] pick_char();
    bit [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_START || c == CH_SEP || c == CH_END);
    return c;
  endfunction

  function automatic bit [63:0] rand_address();
    bit [63:0] a;
    for (int k = 0; k < 8; k++) a[8*k +: 8] = pick_char();
    return a;
  endfunction

  // Check character for a frame whose bytes so far are in q.
  function automatic bit [7:0] check_of(input bit [7:0] q[$]);
    int s;
    s = 0;
    foreach (q[i]) s = (s + q[i]) % 255;
    if (s == CH_START || s == CH_SEP) return CH_SUBST;
    return 8'(s);
  endfunction

  task automatic push_item(bit mode, bit [7:0] b);
    tx_items.push_back('{mode, b});
    phase_items++;
  endtask

  task automatic push_bytes(input bit [7:0] q[$]);
    foreach (q[i]) push_item(MODE_BYTE, q[i]);
  endtask

  task automatic write_reg(bit idx, bit [63:0] value);
    @(posedge clk);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_wr_en <= 0;
    sb.set_register(idx, value);
  endtask

  task automatic settle();
    while (tx_items.size() != 0 || sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly well-formed frames aimed at the current address, some with broken tails.
  task automatic push_frame();
    bit [7:0] body[$];
    int       own_n;
    int       r;
    int       n;
    int       shape;
    bit [7:0] c;
    own_n = (len_now > 8) ? 8 : len_now;
    body.push_back(CH_START);
    r = $urandom_range(0, 9);
    if (r < 8) begin
      for (int k = 0; k < own_n; k++) body.push_back(addr_now[8*k +: 8]);
      if (r >= 6) begin
        n = $urandom_range(1, 3);
        repeat (n) body.push_back(pick_char());
      end
    end else begin
      n = $urandom_range(0, 10);
      repeat (n) body.push_back(pick_char());
    end
    body.push_back(CH_SEP);
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 11) : $urandom_range(0, 8);
    repeat (n) body.push_back(pick_char());
    body.push_back(CH_SEP);
    shape = $urandom_range(0, 19);
    if (shape < 2) begin
      body.push_back(check_of(body));
    end else begin
      r = $urandom_range(0, 9);
      n = (r < 7) ? $urandom_range(0, 5) : (r < 9) ? $urandom_range(6, 32)
                                                   : $urandom_range(33, 40);
      repeat (n) body.push_back(pick_char());
      body.push_back(CH_SEP);
      if (shape != 2) begin
        c = check_of(body);
        if ($urandom_range(0, 9) == 0) c = 8'($urandom_range(0, 255));
        body.push_back(c);
        if (shape < 5) begin
          body.push_back(CH_SEP);
          n = $urandom_range(0, 2);
          repeat (n) body.push_back(pick_char());
        end
      end
    end
    body.push_back(CH_END);
    push_bytes(body);

    r = $urandom_range(0, 9);
    if (r < 8) begin
      if (r >= 6) begin
        n = $urandom_range(1, 3);
        repeat (n) push_item(MODE_BYTE, 8'($urandom_range(0, 255)));
      end
      push_item(MODE_RELEASE, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic push_noise();
    int n;
    n = $urandom_range(1, 4);
    if ($urandom_range(0, 1) == 0) begin
      // A frame that is cut short; the next start character restarts it.
      push_item(MODE_BYTE, CH_START);
      repeat (n) push_item(MODE_BYTE, pick_char());
      if ($urandom_range(0, 1) == 0) push_item(MODE_BYTE, CH_SEP);
    end else begin
      repeat (n) push_item(($urandom_range(0, 3) == 0) ? MODE_RELEASE : MODE_BYTE,
                           8'($urandom_range(0, 255)));
    end
  endtask

  // Sender side of the input stream.
  initial begin : sender
    bit offering;
    offering = 0;
    in_tvalid <= 0;
    in_tdata <= 0;
    in_tuser <= 0;
    forever begin
      if (tx_items.size() == 0) begin
        if (offering) begin
          in_tvalid <= 0;
          offering = 0;
        end
        @(posedge clk);
      end else begin
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
          in_tvalid <= 0;
          offering = 0;
          repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_tvalid <= 1;
        in_tdata <= tx_items[0].value;
        in_tuser <= tx_items[0].mode;
        offering = 1;
        do @(posedge clk); while (!in_tready);
        sb.absorb_item(tx_items[0].mode, tx_items[0].value);
        void'(tx_items.pop_front());
        if ($urandom_range(0, 31) == 0) gap_pct = pick_rate();
      end
    end
  end

  // Receiver side: random stall bursts, plus one long hold-off that backs up the input.
  initial begin : receiver
    out_tready <= 1;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 0;
        out_tready <= 0;
        repeat (300) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_tready <= 0;
        repeat ($urandom_range(0, 14)) @(posedge clk);
      end else begin
        out_tready <= 1;
      end
      if ($urandom_range(0, 63) == 0) stall_pct = pick_rate();
    end
  end

  always @(posedge clk) begin : reply_watch
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tdata[2:0];
      got.kind = out_tuser;
      got.char_value = out_tdata[10:3];
      got.command_length = out_tdata[14:11];
      got.data_length = out_tdata[20:15];
      got.last = out_tlast;
      sb.match_reply(got);
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : main
    bit [7:0] q[$];
    rst_n <= 0;
    cfg_wr_en <= 0;
    cfg_index <= 0;
    cfg_data <= 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;

    // Directed beats with the reset address (empty, so an empty address field matches).
    push_item(MODE_BYTE, 8'hFF);
    push_item(MODE_BYTE, 8'h00);
    push_item(MODE_RELEASE, 8'hFF);
    q = '{CH_START, CH_SEP, CH_SEP};
    push_bytes(q);
    push_item(MODE_BYTE, check_of(q));
    push_item(MODE_BYTE, CH_END);
    push_item(MODE_BYTE, 8'h41);
    push_item(MODE_RELEASE, 8'h00);
    push_item(MODE_BYTE, CH_START);
    push_item(MODE_BYTE, CH_END);
    push_item(MODE_RELEASE, 8'h00);
    q = '{CH_START, CH_SEP, CH_SEP, CH_SEP};
    push_bytes(q);
    push_item(MODE_BYTE, CH_END);
    push_item(MODE_BYTE, CH_START);
    push_item(MODE_BYTE, 8'h5A);
    q = '{CH_START, CH_SEP, 8'h78, CH_SEP, 8'h79, CH_SEP};
    push_bytes(q);
    push_item(MODE_BYTE, check_of(q));
    push_item(MODE_BYTE, CH_END);
    push_item(MODE_RELEASE, 8'h00);
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin addr_now = rand_address(); len_now = 8; end
        1: begin addr_now = '1; len_now = 8; long_hold_req = 1; end
        2: begin addr_now = '0; len_now = 3; end
        3: begin addr_now = rand_address(); len_now = 15; end
        4: begin addr_now = rand_address(); len_now = 1; end
        default: begin addr_now = rand_address(); len_now = 0; quiet = 1; end
      endcase
      write_reg(CFG_OWN_ADDRESS, addr_now);
      // Upper bits of the length write are don't-care; one phase sets them all.
      write_reg(CFG_OWN_ADDRESS_LEN, (p == 2) ? {60'hFFF_FFFF_FFFF_FFFF, len_now}
                                              : {60'd0, len_now});
      phase_items = 0;
      while (phase_items < 28) begin
        if ($urandom_range(0, 9) < 7) push_frame();
        else push_noise();
      end
      push_item(MODE_RELEASE, 8'($urandom_range(0, 255)));
      settle();
    end

    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
